FILE: hw/rtl/dpw_pkg.sv
`timescale 1ns / 1ps

package dpw_pkg;

    // Field and register widths.
    localparam int FREQ_W   = 32;
    localparam int SAMPLE_W = 16;
    localparam int SR_W     = 18;
    localparam int TOR_W    = 32;
    localparam int PHASE_W  = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Shared multiplier operand and product widths.
    localparam int MUL_W  = 32;
    localparam int PROD_W = 2 * MUL_W;

    // Divider: the quotient is limited to 31 bits, one bit per step.
    localparam int DIV_STEPS = 31;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int REM0_W    = 46;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TWO_OVER_RATE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_PHASE = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [SR_W-1:0]    SAMPLE_RATE_RST   = 18'd48000;
    localparam logic [TOR_W-1:0]   TWO_OVER_RATE_RST = 32'd178957;
    localparam logic [PHASE_W-1:0] INITIAL_PHASE_RST = 32'd0;

    // Output saturation limits on the rounded magnitude.
    localparam logic [31:0] POS_LIMIT = 32'd32767;
    localparam logic [31:0] NEG_LIMIT = 32'd32768;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 16'h8000;
    localparam logic [PROD_W-1:0]   ROUND_HALF = 64'h0000_0000_8000_0000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INC,
        S_PHASE,
        S_SQ,
        S_DIFF,
        S_DEN_LO,
        S_DEN_HI,
        S_NUM,
        S_DIV_START,
        S_DIV_WAIT,
        S_OUT_MUL,
        S_OUT
    } t_state;

    typedef struct packed {
        logic              start;
        logic [REM0_W-1:0] rem0;
        logic [PROD_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_STEPS-1:0] quot;
    } t_div_rsp;

endpackage

FILE: hw/rtl/dpw_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. The quotient saturates to all
// ones when the initial partial remainder is not below the divisor.
module dpw_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dpw_pkg::t_div_req i_req,
    output dpw_pkg::t_div_rsp o_rsp
);

    logic                           r_busy, n_busy;
    logic                           r_done, n_done;
    logic                           r_sat, n_sat;
    logic [dpw_pkg::DIV_CNT_W-1:0]  r_cnt, n_cnt;
    logic [dpw_pkg::PROD_W-1:0]     r_rem, n_rem;
    logic [dpw_pkg::PROD_W-1:0]     r_den, n_den;
    logic [dpw_pkg::DIV_STEPS-1:0]  r_quot, n_quot;

    logic [dpw_pkg::PROD_W:0] trial;
    logic [dpw_pkg::PROD_W:0] diff;
    logic                     fits;

    assign trial = {r_rem, 1'b0};
    assign diff  = trial - {1'b0, r_den};
    assign fits  = trial >= {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_sat  = r_sat;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_quot = r_quot;
        priority if (i_req.start) begin
            n_busy = 1'b1;
            n_sat  = {{(dpw_pkg::PROD_W - dpw_pkg::REM0_W){1'b0}}, i_req.rem0} >= i_req.den;
            n_rem  = {{(dpw_pkg::PROD_W - dpw_pkg::REM0_W){1'b0}}, i_req.rem0};
            n_den  = i_req.den;
            n_cnt  = '0;
            n_quot = '0;
        end else if (r_busy) begin
            if (r_sat) begin
                n_quot = '1;
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_rem  = fits ? diff[dpw_pkg::PROD_W-1:0] : trial[dpw_pkg::PROD_W-1:0];
                n_quot = {r_quot[dpw_pkg::DIV_STEPS-2:0], fits};
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == dpw_pkg::DIV_CNT_W'(dpw_pkg::DIV_STEPS - 1)) begin
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end
            end
        end else begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sat  <= n_sat;
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_quot <= n_quot;
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

FILE: hw/rtl/dpw_sawtooth_oscillator.sv
`timescale 1ns / 1ps

// Anti-aliased sawtooth oscillator (differentiated parabolic wave). Each
// frequency transfer (signed Q18.14 Hz) yields one signed Q1.15 sample
// transfer. The phase advances by frequency times two_over_rate, wraps modulo
// two, is squared, and the change of the square is scaled by
// SR / (8 f (1 - f/SR)) and saturated. One 32 by 32 multiplier is shared by
// every product under a small sequencer. A sample whose frequency equals the
// previous one reuses the stored scale. A new frequency adds the scale
// computation: the divider operands are formed in S_DEN_LO, S_DEN_HI, S_NUM
// and S_DIV_START, then a 31-step restoring divider runs. A scale that
// saturates ends the divider without stepping through the quotient bits, and
// a zero denominator skips the divider entirely. The input is stalled until
// the sequence returns to idle, but a new frequency may be taken while the
// last sample still waits in the output register; a stalled output then
// holds the sequence in its final state, which extends the input stall.
// A write to initial_phase also reloads the phase at once; write
// configuration only while the block is idle.
module dpw_sawtooth_oscillator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [dpw_pkg::FREQ_W-1:0]   i_frequency,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [dpw_pkg::SAMPLE_W-1:0] o_sample,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [dpw_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [dpw_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    dpw_pkg::t_state r_state, n_state;

    // Configuration and oscillator state.
    logic [dpw_pkg::SR_W-1:0]     r_sample_rate, n_sample_rate;
    logic [dpw_pkg::TOR_W-1:0]    r_two_over_rate, n_two_over_rate;
    logic [dpw_pkg::PHASE_W-1:0]  r_phase, n_phase;
    logic [31:0]                  r_last_sq, n_last_sq;
    logic [dpw_pkg::FREQ_W-1:0]   r_last_freq, n_last_freq;
    logic [31:0]                  r_scale, n_scale;

    // Working registers of the current item.
    logic [dpw_pkg::FREQ_W-1:0]   r_freq, n_freq;
    logic [dpw_pkg::PROD_W-1:0]   r_prod;
    logic [dpw_pkg::PROD_W-1:0]   r_den, n_den;
    logic [32:0]                  r_diff, n_diff;
    logic [dpw_pkg::SAMPLE_W-1:0] r_sample, n_sample;
    logic                         r_out_valid, n_out_valid;

    // Shared multiplier.
    logic                         mul_en;
    logic [dpw_pkg::MUL_W-1:0]    mul_a, mul_b;

    dpw_pkg::t_div_req div_req;
    dpw_pkg::t_div_rsp div_rsp;

    // Derived values of the current item.
    logic [31:0]                  f_mag;
    logic [33:0]                  g_val;
    logic [33:0]                  g_mag;
    logic                         den_zero;
    logic                         scale_neg;
    logic [dpw_pkg::PROD_W-1:0]   inc_prod;
    logic [31:0]                  inc;
    logic [31:0]                  phase_mag;
    logic [31:0]                  sq;
    logic [32:0]                  diff_abs;
    logic [31:0]                  scale_mag;
    logic [dpw_pkg::PROD_W-1:0]   out_round;
    logic [31:0]                  out_mag;
    logic                         out_neg;
    logic [dpw_pkg::SAMPLE_W-1:0] out_sat;
    logic [31:0]                  quot_ext;

    dpw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Frequency magnitude; the most negative code maps to 2^31 unsigned.
    assign f_mag = r_freq[31] ? (32'd0 - r_freq) : r_freq;

    // Second denominator term SR * 2^14 - F, which needs 34 signed bits.
    assign g_val     = {2'b00, r_sample_rate, 14'b0} - {{2{r_freq[31]}}, r_freq};
    assign g_mag     = g_val[33] ? (34'd0 - g_val) : g_val;
    assign den_zero  = (r_freq == '0) || (g_val == '0);
    assign scale_neg = r_freq[31] ^ g_val[33];

    // The increment product is formed on magnitudes; negating the full product
    // before the shift keeps the floor rounding of a signed shift.
    assign inc_prod = r_freq[31] ? (64'd0 - r_prod) : r_prod;
    assign inc      = inc_prod[46:15];

    assign phase_mag = r_phase[31] ? (32'd0 - r_phase) : r_phase;
    assign sq        = r_prod[62:31];

    // The difference of two squares stays within 2^31 in magnitude.
    assign diff_abs  = r_diff[32] ? (33'd0 - r_diff) : r_diff;
    assign scale_mag = r_scale[31] ? (32'd0 - r_scale) : r_scale;

    // Round to nearest, ties away from zero, then saturate on the sign.
    assign out_round = r_prod + dpw_pkg::ROUND_HALF;
    assign out_mag   = out_round[63:32];
    assign out_neg   = r_diff[32] ^ r_scale[31];

    always_comb begin
        if (out_neg && (out_mag != 32'd0)) begin
            if (out_mag > dpw_pkg::NEG_LIMIT) begin
                out_sat = dpw_pkg::SAMPLE_MIN;
            end else begin
                out_sat = 16'(32'd0 - out_mag);
            end
        end else if (out_mag > dpw_pkg::POS_LIMIT) begin
            out_sat = dpw_pkg::SAMPLE_MAX;
        end else begin
            out_sat = out_mag[15:0];
        end
    end

    assign quot_ext = {1'b0, div_rsp.quot};

    always_comb begin
        n_state         = r_state;
        n_sample_rate   = r_sample_rate;
        n_two_over_rate = r_two_over_rate;
        n_phase         = r_phase;
        n_last_sq       = r_last_sq;
        n_last_freq     = r_last_freq;
        n_scale         = r_scale;
        n_freq          = r_freq;
        n_den           = r_den;
        n_diff          = r_diff;
        n_sample        = r_sample;
        n_out_valid     = r_out_valid;
        mul_en          = 1'b0;
        mul_a           = '0;
        mul_b           = '0;
        div_req.start   = 1'b0;
        div_req.rem0    = '0;
        div_req.den     = r_den;

        // The held sample leaves once the receiver stops stalling.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            dpw_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_freq  = i_frequency;
                    n_state = dpw_pkg::S_INC;
                end
            end
            dpw_pkg::S_INC: begin
                mul_en  = 1'b1;
                mul_a   = f_mag;
                mul_b   = r_two_over_rate;
                n_state = dpw_pkg::S_PHASE;
            end
            dpw_pkg::S_PHASE: begin
                n_phase = r_phase + inc;
                n_state = dpw_pkg::S_SQ;
            end
            dpw_pkg::S_SQ: begin
                mul_en  = 1'b1;
                mul_a   = phase_mag;
                mul_b   = phase_mag;
                n_state = dpw_pkg::S_DIFF;
            end
            dpw_pkg::S_DIFF: begin
                n_diff    = {1'b0, sq} - {1'b0, r_last_sq};
                n_last_sq = sq;
                if (r_freq != r_last_freq) begin
                    n_last_freq = r_freq;
                    if (den_zero) begin
                        n_scale = '0;
                        n_state = dpw_pkg::S_OUT_MUL;
                    end else begin
                        n_state = dpw_pkg::S_DEN_LO;
                    end
                end else begin
                    n_state = dpw_pkg::S_OUT_MUL;
                end
            end
            dpw_pkg::S_DEN_LO: begin
                mul_en  = 1'b1;
                mul_a   = f_mag;
                mul_b   = g_mag[31:0];
                n_state = dpw_pkg::S_DEN_HI;
            end
            dpw_pkg::S_DEN_HI: begin
                // The second term reaches 33 bits; its top bit adds |F| * 2^32.
                n_den   = r_prod + (g_mag[32] ? {f_mag, 32'b0} : 64'b0);
                n_state = dpw_pkg::S_NUM;
            end
            dpw_pkg::S_NUM: begin
                mul_en  = 1'b1;
                mul_a   = {{(dpw_pkg::MUL_W - dpw_pkg::SR_W){1'b0}}, r_sample_rate};
                mul_b   = {{(dpw_pkg::MUL_W - dpw_pkg::SR_W){1'b0}}, r_sample_rate};
                n_state = dpw_pkg::S_DIV_START;
            end
            dpw_pkg::S_DIV_START: begin
                // SR^2 * 2^41 / D; the top part SR^2 * 2^10 is the first
                // partial remainder and the remaining dividend bits are zero.
                div_req.start = 1'b1;
                div_req.rem0  = {r_prod[35:0], 10'b0};
                n_state       = dpw_pkg::S_DIV_WAIT;
            end
            dpw_pkg::S_DIV_WAIT: begin
                if (div_rsp.done) begin
                    n_scale = scale_neg ? (32'd0 - quot_ext) : quot_ext;
                    n_state = dpw_pkg::S_OUT_MUL;
                end
            end
            dpw_pkg::S_OUT_MUL: begin
                mul_en  = 1'b1;
                mul_a   = diff_abs[31:0];
                mul_b   = scale_mag;
                n_state = dpw_pkg::S_OUT;
            end
            dpw_pkg::S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_sample    = out_sat;
                    n_out_valid = 1'b1;
                    n_state     = dpw_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dpw_pkg::S_IDLE;
            end
        endcase

        if (i_cfg_valid) begin
            priority case (i_cfg_index)
                dpw_pkg::CFG_SAMPLE_RATE:   n_sample_rate   = i_cfg_data[dpw_pkg::SR_W-1:0];
                dpw_pkg::CFG_TWO_OVER_RATE: n_two_over_rate = i_cfg_data;
                dpw_pkg::CFG_INITIAL_PHASE: n_phase         = i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= dpw_pkg::S_IDLE;
            r_out_valid     <= 1'b0;
            r_sample_rate   <= dpw_pkg::SAMPLE_RATE_RST;
            r_two_over_rate <= dpw_pkg::TWO_OVER_RATE_RST;
            r_phase         <= dpw_pkg::INITIAL_PHASE_RST;
            r_last_sq       <= '0;
            r_last_freq     <= '0;
            r_scale         <= '0;
        end else begin
            r_state         <= n_state;
            r_out_valid     <= n_out_valid;
            r_sample_rate   <= n_sample_rate;
            r_two_over_rate <= n_two_over_rate;
            r_phase         <= n_phase;
            r_last_sq       <= n_last_sq;
            r_last_freq     <= n_last_freq;
            r_scale         <= n_scale;
        end
    end

    always_ff @(posedge i_clk) begin
        r_freq   <= n_freq;
        r_den    <= n_den;
        r_diff   <= n_diff;
        r_sample <= n_sample;
        if (mul_en) begin
            r_prod <= mul_a * mul_b;
        end
    end

    assign o_in_stall  = (r_state != dpw_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_sample    = r_sample;
    assign o_cfg_ready = 1'b1;

    // A frequency transfer always starts a multi-cycle computation.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after a transfer");

    // The divider is only started when it has finished the previous quotient.
    a_div_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dpw_pkg::S_DIV_START) |-> !div_rsp.busy)
        else $error("divider started while busy");

    // A quotient only arrives while the sequencer waits for it.
    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == dpw_pkg::S_DIV_WAIT))
        else $error("quotient arrived outside the wait state");

    // A new sample is only loaded from the final state of the sequence.
    a_out_from_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == dpw_pkg::S_OUT))
        else $error("sample loaded outside the output state");

    // After the difference step the stored frequency matches the current one.
    a_last_freq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dpw_pkg::S_DIFF) |=> (r_last_freq == r_freq))
        else $error("last frequency not updated");

endmodule

FILE: sim/dpw_sawtooth_oscillator_test.sv
`timescale 1ns / 1ps

// Self-checking bench for the DPW sawtooth oscillator. A clocked driver takes
// frequency items from a backlog queue and offers them on the input channel; a
// clocked monitor accepts sample transfers and compares each one with the
// oldest predicted sample. The predictor below keeps its own copy of the phase,
// the previous square, the previous frequency and the scale factor, and it is
// updated at every accepted frequency transfer and at every register write.
module dpw_sawtooth_oscillator_test;

    // Idle cycles before a register write, and at the very end.
    localparam int unsigned SETTLE_CYCLES = 48;
    localparam int unsigned END_CYCLES    = 64;
    // Length of the one long receiver hold-off.
    localparam int unsigned HOLD_CYCLES   = 400;
    // Cycles without any transfer before the run is declared hung.
    localparam int unsigned HANG_LIMIT    = 4000;
    localparam int unsigned RAND_PHASES   = 12;
    localparam int unsigned PHASE_ITEMS   = 80;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Input channel.
    logic                         in_valid  = 1'b0;
    logic [dpw_pkg::FREQ_W-1:0]   in_freq   = '0;
    logic                         in_stall;
    // Output channel.
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [dpw_pkg::SAMPLE_W-1:0] out_sample;
    // Configuration channel.
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [dpw_pkg::CFG_IDX_W-1:0]  cfg_index = dpw_pkg::CFG_SAMPLE_RATE;
    logic [dpw_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    dpw_sawtooth_oscillator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_frequency (in_freq),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_sample    (out_sample),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Frequencies waiting to be offered, and samples waiting to arrive.
    logic [dpw_pkg::FREQ_W-1:0]   freq_backlog[$];
    logic [dpw_pkg::SAMPLE_W-1:0] pending_samples[$];

    int unsigned fault_count = 0;
    int unsigned send_gap    = 0;
    int unsigned recv_gap    = 0;
    int unsigned hold_left   = 0;
    int unsigned idle_cycles = 0;
    // Set by the sequence: no idling on either side, or one long hold-off.
    bit          quiet       = 1'b0;
    bit          hold_req    = 1'b0;

    // Predictor copy of the configuration registers.
    logic [dpw_pkg::SR_W-1:0]  cfg_rate = dpw_pkg::SAMPLE_RATE_RST;
    logic [dpw_pkg::TOR_W-1:0] cfg_step = dpw_pkg::TWO_OVER_RATE_RST;
    // Predictor copy of the oscillator state.
    logic [31:0] osc_phase   = dpw_pkg::INITIAL_PHASE_RST;
    logic [31:0] prev_square = '0;
    logic [31:0] prev_freq   = '0;
    logic [31:0] osc_scale   = '0;

    // Scale factor SR^2 * 2^41 / (F * (SR * 2^14 - F)) in signed Q16.16. The
    // magnitude is truncated and capped at 2^31 - 1 before the sign goes on.
    // A zero frequency or a zero second term gives zero.
    function automatic logic [31:0] dpw_scale_for(input logic [31:0] fbits);
        logic [65:0]  f_ext;
        logic [65:0]  g_ext;
        logic [65:0]  f_mag;
        logic [65:0]  g_mag;
        logic [127:0] den;
        logic [127:0] num;
        logic [127:0] quo;
        logic [31:0]  q;
        logic         neg;
        f_ext = {{34{fbits[31]}}, fbits};
        g_ext = {34'b0, cfg_rate, 14'b0} - f_ext;
        if (f_ext == '0 || g_ext == '0) begin
            return '0;
        end
        neg   = f_ext[65] ^ g_ext[65];
        f_mag = f_ext[65] ? -f_ext : f_ext;
        g_mag = g_ext[65] ? -g_ext : g_ext;
        den   = f_mag;
        den   = den * g_mag;
        num   = cfg_rate;
        num   = num * cfg_rate;
        num   = num << 41;
        quo   = num / den;
        q     = (quo > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo[31:0];
        return neg ? -q : q;
    endfunction

    // Advances the oscillator by one frequency sample and returns the sample.
    function automatic logic [dpw_pkg::SAMPLE_W-1:0] saw_sample_from(input logic [31:0] fbits);
        logic [63:0] inc_prod;
        logic [32:0] phase_mag;
        logic [63:0] phase_sq;
        logic [31:0] square;
        logic [32:0] diff;
        logic [32:0] diff_mag;
        logic [32:0] scale_mag;
        logic [63:0] scaled;
        logic [31:0] mag;
        logic        neg;
        inc_prod  = {{32{fbits[31]}}, fbits} * {32'b0, cfg_step};
        osc_phase = osc_phase + inc_prod[46:15];
        // The phase -1 has magnitude 2^31, so its square is exactly 1.0.
        phase_mag = osc_phase[31] ? (33'h1_0000_0000 - {1'b0, osc_phase})
                                  : {1'b0, osc_phase};
        phase_sq  = {31'b0, phase_mag} * {31'b0, phase_mag};
        square    = phase_sq[62:31];
        diff      = {1'b0, square} - {1'b0, prev_square};
        prev_square = square;
        // The divider runs only when the frequency bits change.
        if (fbits != prev_freq) begin
            prev_freq = fbits;
            osc_scale = dpw_scale_for(fbits);
        end
        diff_mag  = diff[32] ? -diff : diff;
        scale_mag = osc_scale[31] ? (33'h1_0000_0000 - {1'b0, osc_scale})
                                  : {1'b0, osc_scale};
        neg       = diff[32] ^ osc_scale[31];
        // Round to nearest, ties away from zero, on the magnitude.
        scaled    = {31'b0, diff_mag} * {31'b0, scale_mag} + dpw_pkg::ROUND_HALF;
        mag       = scaled[63:32];
        if (neg && mag != '0) begin
            if (mag > dpw_pkg::NEG_LIMIT) begin
                mag = dpw_pkg::NEG_LIMIT;
            end
            return 16'h0000 - mag[15:0];
        end
        if (mag > dpw_pkg::POS_LIMIT) begin
            mag = dpw_pkg::POS_LIMIT;
        end
        return mag[15:0];
    endfunction

    // Raw Q18.14 bits of a whole number of hertz.
    function automatic logic [31:0] q14(input int hz);
        return hz * 16384;
    endfunction

    // Random frequency for the current sample rate. Repeats are common so that
    // the path without a new scale computation gets plenty of traffic.
    function automatic logic [31:0] pick_frequency(input logic [31:0] last);
        int unsigned sel;
        int unsigned top;
        logic [31:0] audio;
        sel   = $urandom_range(0, 99);
        top   = (cfg_rate / 2 > 1) ? cfg_rate / 2 : 1;
        audio = ($urandom_range(1, top) << 14) | $urandom_range(0, 16383);
        if (sel < 35) begin
            return last;
        end else if (sel < 68) begin
            return audio;
        end else if (sel < 78) begin
            return -audio;
        end else if (sel < 93) begin
            return $urandom();
        end else if (sel < 96) begin
            return '0;
        end
        return {cfg_rate, 14'b0};
    endfunction

    // Driver: offers the next backlog item once the current one has been taken,
    // after a random number of idle cycles, or none while quiet is set.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                pending_samples.push_back(saw_sample_from(in_freq));
            end
            if (!in_valid || !in_stall) begin
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                    in_valid <= 1'b0;
                end else if (freq_backlog.size() > 0) begin
                    in_freq  <= freq_backlog.pop_front();
                    in_valid <= 1'b1;
                    send_gap = quiet ? 0 : $urandom_range(0, 4);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks every sample transfer against the oldest prediction and
    // draws its own stall pattern, including the single long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (pending_samples.size() == 0) begin
                    if (fault_count < 10) begin
                        $display("unexpected sample %0d at %0t", $signed(out_sample), $realtime);
                    end
                    fault_count = fault_count + 1;
                end else if (out_sample !== pending_samples[0]) begin
                    if (fault_count < 10) begin
                        $display("sample mismatch: expected %0d, got %0d at %0t",
                                 $signed(pending_samples[0]), $signed(out_sample), $realtime);
                    end
                    fault_count = fault_count + 1;
                    void'(pending_samples.pop_front());
                end else begin
                    void'(pending_samples.pop_front());
                end
                recv_gap = quiet ? 0 : $urandom_range(0, 4);
            end
            if (hold_req && hold_left == 0) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                out_stall <= 1'b1;
            end else if (recv_gap > 0) begin
                recv_gap = recv_gap - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: any cycle with a transfer on some channel clears the count.
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
        end
        if (idle_cycles >= HANG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // One register write; the predictor follows once the transfer is done.
    task automatic write_register(input logic [dpw_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [31:0] value);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do begin
            @(posedge i_clk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            dpw_pkg::CFG_SAMPLE_RATE: begin
                cfg_rate = value[dpw_pkg::SR_W-1:0];
            end
            dpw_pkg::CFG_TWO_OVER_RATE: begin
                cfg_step = value;
            end
            dpw_pkg::CFG_INITIAL_PHASE: begin
                // Writing the start phase also reloads the running phase.
                osc_phase = value;
            end
            default: begin
            end
        endcase
    endtask

    // Holds the sequence until every queued frequency has been taken and
    // every predicted sample has arrived.
    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (freq_backlog.size() != 0 || in_valid || pending_samples.size() != 0);
    endtask

    // Drains, then lets the block settle before the registers change.
    task automatic end_phase();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] last_freq;
        logic [31:0] rate;
        logic [31:0] step;
        logic [31:0] start;
        int unsigned sel;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: zero frequency, a repeat, frequency equal to the
        // sample rate, a tiny frequency that saturates the scale, and the
        // signed extremes with their huge phase steps.
        @(negedge i_clk);
        freq_backlog.push_back('0);
        freq_backlog.push_back(q14(440));
        freq_backlog.push_back(q14(440));
        freq_backlog.push_back(q14(48000));
        freq_backlog.push_back(32'h0000_0001);
        freq_backlog.push_back(q14(-440));
        freq_backlog.push_back(32'h7FFF_FFFF);
        freq_backlog.push_back(32'h8000_0000);
        freq_backlog.push_back(32'hFFFF_FFFF);
        freq_backlog.push_back(q14(24000));
        end_phase();

        // Sample rate 8000. The first item repeats the last frequency, so the
        // scale computed for the old rate stays in use.
        write_register(dpw_pkg::CFG_SAMPLE_RATE, 32'd8000);
        write_register(dpw_pkg::CFG_TWO_OVER_RATE, 32'd1073741);
        write_register(dpw_pkg::CFG_INITIAL_PHASE, 32'h4000_0000);
        @(negedge i_clk);
        freq_backlog.push_back(q14(24000));
        freq_backlog.push_back(q14(8000));
        freq_backlog.push_back(q14(1000));
        end_phase();

        // Largest increment per hertz with a start at phase -1: large phase
        // differences against a large scale drive the output into saturation.
        write_register(dpw_pkg::CFG_TWO_OVER_RATE, 32'hFFFF_FFFF);
        write_register(dpw_pkg::CFG_INITIAL_PHASE, 32'h8000_0000);
        write_register(dpw_pkg::CFG_SAMPLE_RATE, 32'd192000);
        @(negedge i_clk);
        freq_backlog.push_back(q14(1));
        freq_backlog.push_back(q14(1));
        freq_backlog.push_back(q14(3));
        freq_backlog.push_back(32'h0000_4001);
        freq_backlog.push_back(q14(-2));
        end_phase();

        // Zero sample rate gives a zero numerator; zero increment freezes the
        // phase at its start value.
        write_register(dpw_pkg::CFG_SAMPLE_RATE, 32'd0);
        write_register(dpw_pkg::CFG_TWO_OVER_RATE, 32'd0);
        write_register(dpw_pkg::CFG_INITIAL_PHASE, 32'h7FFF_FFFF);
        @(negedge i_clk);
        freq_backlog.push_back(q14(440));
        freq_backlog.push_back(q14(1000));
        end_phase();

        // All ones in the sample rate register.
        write_register(dpw_pkg::CFG_SAMPLE_RATE, 32'h0003_FFFF);
        write_register(dpw_pkg::CFG_TWO_OVER_RATE, 32'd32768);
        @(negedge i_clk);
        freq_backlog.push_back(q14(100000));
        freq_backlog.push_back(32'h5555_AAAA);
        end_phase();

        last_freq = 32'h5555_AAAA;
        for (int unsigned p = 0; p < RAND_PHASES; p++) begin
            case (p % 6)
                0: rate = 32'd8000;
                1: rate = 32'd192000;
                2: rate = $urandom_range(8000, 192000);
                3: rate = 32'h0003_FFFF;
                4: rate = 32'd48000;
                default: rate = $urandom_range(0, 32'h0003_FFFF);
            endcase
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
                step = 32'h0;
            end else if (sel == 1) begin
                step = 32'hFFFF_FFFF;
            end else if (sel < 4 || rate == 0) begin
                step = $urandom();
            end else begin
                step = 32'((64'd1 << 33) / rate);
            end
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
                start = 32'h8000_0000;
            end else if (sel == 1) begin
                start = 32'h7FFF_FFFF;
            end else if (sel == 2) begin
                start = 32'h0;
            end else begin
                start = $urandom();
            end
            write_register(dpw_pkg::CFG_SAMPLE_RATE, rate);
            write_register(dpw_pkg::CFG_TWO_OVER_RATE, step);
            // Some phases keep the running phase instead of reloading it.
            if (p % 3 != 1) begin
                write_register(dpw_pkg::CFG_INITIAL_PHASE, start);
            end

            @(negedge i_clk);
            quiet = (p % 5 == 2);
            for (int unsigned k = 0; k < PHASE_ITEMS / 2; k++) begin
                last_freq = pick_frequency(last_freq);
                freq_backlog.push_back(last_freq);
            end
            // One long hold-off on the receiver while the sender keeps going,
            // so that the block backs up and stalls its input.
            if (p == 3) begin
                hold_req = 1'b1;
            end
            // The sender pauses here until every sample so far has arrived.
            wait_drained();
            for (int unsigned k = 0; k < PHASE_ITEMS / 2; k++) begin
                last_freq = pick_frequency(last_freq);
                freq_backlog.push_back(last_freq);
            end
            end_phase();
            quiet = 1'b0;
        end

        wait_drained();
        repeat (END_CYCLES) @(posedge i_clk);
        fault_count = fault_count + pending_samples.size();
        if (fault_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/dpw_pkg.sv
hw/rtl/dpw_div.sv
hw/rtl/dpw_sawtooth_oscillator.sv
sim/dpw_sawtooth_oscillator_test.sv
